>>> hdl/acf_pkg.sv
package acf_pkg;

  localparam int FRAMES_DEF   = 256;
  localparam int PEAK_CAP_DEF = 32;
  localparam int CFG_IDX_W    = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROM_MIN    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 8'd3;

  localparam logic signed [15:0] MIN_HEIGHT_RST  = 16'sd1638;
  localparam logic [8:0]         MIN_WIDTH_RST   = 9'd3;
  localparam logic [15:0]        PROM_MIN_RST    = 16'd1638;
  localparam logic [7:0]         SAMPLE_RATE_RST = 8'd25;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } acf_in_t;

  typedef struct packed {
    logic [7:0] peak_lag;
    logic       found;
    logic       truncated;
    logic       is_last;
  } acf_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic sm_wr;
    logic pk_take_v;
    logic pk_take_l;
    logic win_init;
    logic win_rd;
    logic win_step;
    logic pr_rd;
    logic pr_chk;
    logic step;
    logic emit_none;
    logic emit_rd;
    logic emit_out;
    logic done;
  } acf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_lo;
    logic at_hi;
    logic peak_ok;
    logic width_off;
    logic win_fail;
    logic win_end;
    logic no_peaks;
    logic emit_end;
  } acf_stat_t;

endpackage

>>> hdl/acf_ctrl.sv
module acf_ctrl
  import acf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_last,
  input  acf_stat_t stat,
  output acf_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_SETUP = 16'h0002,
    S_SM_RD = 16'h0004,
    S_SM_WR = 16'h0008,
    S_PK_A  = 16'h0010,
    S_PK_B  = 16'h0020,
    S_PK_C  = 16'h0040,
    S_PK_D  = 16'h0080,
    S_WIN_A = 16'h0100,
    S_WIN_B = 16'h0200,
    S_PR_A  = 16'h0400,
    S_PR_B  = 16'h0800,
    S_NEXT  = 16'h1000,
    S_NONE  = 16'h2000,
    S_EM_A  = 16'h4000,
    S_EM_B  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_SM_RD;
      end
      S_SM_RD: begin
        state_nxt = S_SM_WR;
      end
      S_SM_WR: begin
        cmd.sm_wr = 1'b1;
        state_nxt = stat.at_lo ? S_PK_A : S_SM_RD;
      end
      S_PK_A: begin
        state_nxt = S_PK_B;
      end
      S_PK_B: begin
        cmd.pk_take_v = 1'b1;
        state_nxt = S_PK_C;
      end
      S_PK_C: begin
        cmd.pk_take_l = 1'b1;
        state_nxt = S_PK_D;
      end
      S_PK_D: begin
        if (!stat.peak_ok) begin
          state_nxt = S_NEXT;
        end else if (stat.width_off) begin
          state_nxt = S_PR_A;
        end else begin
          cmd.win_init = 1'b1;
          state_nxt = S_WIN_A;
        end
      end
      S_WIN_A: begin
        cmd.win_rd = 1'b1;
        state_nxt = S_WIN_B;
      end
      S_WIN_B: begin
        if (stat.win_fail) begin
          state_nxt = S_NEXT;
        end else if (stat.win_end) begin
          state_nxt = S_PR_A;
        end else begin
          cmd.win_step = 1'b1;
          state_nxt = S_WIN_A;
        end
      end
      S_PR_A: begin
        cmd.pr_rd = 1'b1;
        state_nxt = S_PR_B;
      end
      S_PR_B: begin
        cmd.pr_chk = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (stat.at_hi) begin
          state_nxt = stat.no_peaks ? S_NONE : S_EM_A;
        end else begin
          cmd.step = 1'b1;
          state_nxt = S_PK_A;
        end
      end
      S_NONE: begin
        cmd.emit_none = 1'b1;
        cmd.done      = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_EM_A: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EM_B;
      end
      S_EM_B: begin
        cmd.emit_out = 1'b1;
        if (stat.emit_end) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EM_A;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> hdl/acf_dp.sv
module acf_dp
  import acf_pkg::*;
#(
  parameter int FRAMES   = FRAMES_DEF,
  parameter int PEAK_CAP = PEAK_CAP_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acf_cmd_t             cmd,
  input  logic signed [15:0]   in_sample,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output acf_stat_t            stat,
  output logic                 out_valid,
  output acf_out_t             out_data
);

  localparam int LW = $clog2(FRAMES);
  localparam int RW = (PEAK_CAP > 1) ? $clog2(PEAK_CAP) : 1;
  localparam int NW = $clog2(PEAK_CAP + 1);
  localparam int XW = LW + 10;
  localparam logic [XW-1:0] LAST_LAG = XW'(FRAMES - 1);
  localparam logic [NW-1:0] N_MAX    = NW'(PEAK_CAP);

  // Configuration registers.
  logic signed [15:0] min_height_r;
  logic [8:0]         min_width_r;
  logic [15:0]        prom_min_r;
  logic [7:0]         rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_height_r <= MIN_HEIGHT_RST;
      min_width_r  <= MIN_WIDTH_RST;
      prom_min_r   <= PROM_MIN_RST;
      rate_r       <= SAMPLE_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_HEIGHT:  min_height_r <= cfg_data;
        REG_MIN_WIDTH:   min_width_r  <= cfg_data[8:0];
        REG_PROM_MIN:    prom_min_r   <= cfg_data;
        REG_SAMPLE_RATE: rate_r       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [LW:0]   ld_r;
  logic [LW-1:0] lo_r, hi_r, i_r, j_r, e_r;
  logic signed [15:0] v_r, lm_r, sm_r, sufd_r, rdat_r;
  logic               rok_r, lok_r, trunc_r;
  logic [NW-1:0]      n_r, k_r;
  logic [7:0]         resd_r;

  logic signed [15:0] smem [FRAMES];
  logic signed [15:0] suf  [FRAMES];
  logic [7:0]         res  [PEAK_CAP];

  // Sample store read port; entries at or past the load count read as zero.
  logic [LW-1:0] raddr;
  logic signed [15:0] d;

  always_comb begin
    raddr = i_r;
    if (cmd.pk_take_v) raddr = i_r - LW'(1);
    if (cmd.pk_take_l) raddr = i_r + LW'(1);
    if (cmd.win_rd)    raddr = j_r;
  end

  assign d = rok_r ? rdat_r : 16'sd0;

  always_ff @(posedge clk) begin
    if (cmd.load && !ld_r[LW]) smem[ld_r[LW-1:0]] <= in_sample;
  end

  always_ff @(posedge clk) begin
    rdat_r <= smem[raddr];
    rok_r  <= ({1'b0, raddr} < ld_r);
  end

  // Search range.
  logic [XW-1:0] lo_full, hi_full;
  assign lo_full = XW'({rate_r, 1'b0});
  assign hi_full = XW'((XW'(rate_r) * XW'(15)) >> 1);

  // Suffix minimum.
  logic signed [15:0] sm_new;
  assign sm_new = (i_r == hi_r || d < sm_r) ? d : sm_r;

  always_ff @(posedge clk) begin
    if (cmd.sm_wr) suf[i_r] <= sm_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.pr_rd) sufd_r <= suf[i_r];
  end

  // Window bounds.
  logic [XW-1:0] half, xi, dif_lo, dif_hi;
  logic [LW-1:0] win_s, win_e;
  assign half   = XW'((min_width_r - 9'd1) >> 1);
  assign xi     = XW'(i_r);
  assign dif_lo = XW'(i_r - lo_r);
  assign dif_hi = XW'(hi_r - i_r);
  assign win_s  = (dif_lo > half) ? LW'(xi - half) : lo_r;
  assign win_e  = (dif_hi > half) ? LW'(xi + half) : hi_r;

  // Prominence.
  logic signed [15:0] base;
  logic signed [17:0] prom;
  logic               prom_ok;
  always_comb begin
    if (i_r == lo_r)      base = sufd_r;
    else if (i_r == hi_r) base = lm_r;
    else                  base = (lm_r > sufd_r) ? lm_r : sufd_r;
  end
  assign prom    = 18'(v_r) - 18'(base);
  assign prom_ok = prom >= $signed({2'b00, prom_min_r});

  always_ff @(posedge clk) begin
    if (cmd.pr_chk && prom_ok && (n_r < N_MAX)) res[n_r[RW-1:0]] <= 8'(i_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rd) resd_r <= res[k_r[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r      <= '0;
      out_valid <= 1'b0;
      n_r       <= '0;
      k_r       <= '0;
      trunc_r   <= 1'b0;
    end else begin
      out_valid <= cmd.emit_none | cmd.emit_out;
      if (cmd.load && !ld_r[LW]) ld_r <= ld_r + (LW+1)'(1);
      if (cmd.done) ld_r <= '0;
      if (cmd.setup) begin
        lo_r    <= (lo_full > LAST_LAG) ? LAST_LAG[LW-1:0] : lo_full[LW-1:0];
        hi_r    <= (hi_full > LAST_LAG) ? LAST_LAG[LW-1:0] : hi_full[LW-1:0];
        i_r     <= (hi_full > LAST_LAG) ? LAST_LAG[LW-1:0] : hi_full[LW-1:0];
        n_r     <= '0;
        k_r     <= '0;
        trunc_r <= 1'b0;
      end
      if (cmd.sm_wr) begin
        sm_r <= sm_new;
        if (i_r != lo_r) i_r <= i_r - LW'(1);
      end
      if (cmd.pk_take_v) begin
        v_r  <= d;
        lm_r <= (i_r == lo_r || d < lm_r) ? d : lm_r;
      end
      if (cmd.pk_take_l) lok_r <= (i_r == lo_r) || (v_r > d);
      if (cmd.win_init) begin
        j_r <= win_s;
        e_r <= win_e;
      end
      if (cmd.win_step) j_r <= j_r + LW'(1);
      if (cmd.pr_chk && prom_ok) begin
        if (n_r < N_MAX) n_r <= n_r + NW'(1);
        else             trunc_r <= 1'b1;
      end
      if (cmd.step) i_r <= i_r + LW'(1);
      if (cmd.emit_none) begin
        out_data  <= '{peak_lag: 8'd0, found: 1'b0, truncated: 1'b0, is_last: 1'b1};
      end
      if (cmd.emit_out) begin
        out_data  <= '{peak_lag: resd_r, found: 1'b1, truncated: trunc_r,
                       is_last: (k_r == n_r - NW'(1))};
        k_r <= k_r + NW'(1);
      end
    end
  end

  assign stat.at_lo     = (i_r == lo_r);
  assign stat.at_hi     = (i_r == hi_r);
  assign stat.peak_ok   = lok_r && ((i_r == hi_r) || (v_r > d)) && (v_r >= min_height_r);
  assign stat.width_off = (min_width_r == 9'd0);
  assign stat.win_fail  = (d > v_r);
  assign stat.win_end   = (j_r == e_r);
  assign stat.no_peaks  = (n_r == '0);
  assign stat.emit_end  = (k_r == n_r - NW'(1));

endmodule

>>> hdl/acf_peak_finder.sv
// Autocorrelation peak finder. Each request carries one sample and is taken when
// start is high and busy is low; loading takes one sample per cycle. The request
// that has last set starts a search over lags 2*rate to floor(7.5*rate), clamped to
// FRAMES-1, and busy stays high until every result has been sent. The search time
// is set by the single read port of the sample memory. The search sets up the range,
// makes a right-side minimum pass over the lags, runs the neighbor tests on each
// lag, walks the width window of each candidate unless the minimum width is zero,
// checks the prominence of each candidate that passes, and sends each result (a
// single no-peak result when no peak is found).
// Results appear on out_data for exactly one cycle each, flagged by out_valid; the
// receiver cannot stall, so it must take every result the cycle it is shown.
module acf_peak_finder
  import acf_pkg::*;
#(
  parameter int FRAMES   = FRAMES_DEF,
  parameter int PEAK_CAP = PEAK_CAP_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  acf_in_t              in_data,
  output logic                 out_valid,
  output acf_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  acf_cmd_t  cmd;
  acf_stat_t stat;

  // Always writable; the user must write only while the block is idle (no check).
  assign cfg_ready = 1'b1;

  acf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_data.last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  acf_dp #(
    .FRAMES   (FRAMES),
    .PEAK_CAP (PEAK_CAP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_sample (in_data.sample),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
